// ----- hdl/movs_pkg.sv -----
`default_nettype none
package movs_pkg;
  // register indexes on the configuration port
  localparam logic [0:0] REG_MISSING = 1'b0;
  localparam logic [0:0] REG_BAD     = 1'b1;

  // float relations used by the cells
  typedef struct packed {
    logic lt;  // a < b
    logic eq;  // a == b
  } fcmp_t;

  function automatic logic is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  // IEEE compare of two single bit patterns (NaN unordered)
  function automatic fcmp_t fcmp(input logic [31:0] a, input logic [31:0] b);
    fcmp_t r;
    logic  az;
    logic  bz;
    az = (a[30:0] == 31'd0);
    bz = (b[30:0] == 31'd0);
    r.lt = 1'b0;
    r.eq = 1'b0;
    if (!is_nan(a) && !is_nan(b)) begin
      if (az && bz) begin
        r.eq = 1'b1;
      end else if (a == b) begin
        r.eq = 1'b1;
      end else if (a[31] != b[31]) begin
        r.lt = a[31];
      end else if (!a[31]) begin
        r.lt = (a[30:0] < b[30:0]);
      end else begin
        r.lt = (a[30:0] > b[30:0]);
      end
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- hdl/movs_cell.sv -----
`default_nettype none
module movs_cell
  import movs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        ins,       // insert broadcast this cycle
  input  wire logic        clr,       // start of a new run
  input  wire logic [31:0] new_word,
  input  wire logic        prev_take, // left neighbour takes new or shifts
  input  wire logic [31:0] prev_word,
  input  wire logic        prev_occ,
  output logic             take,      // this cell loads new or shifts from the left
  output logic [31:0]      word,
  output logic             occ
);
  logic [31:0] word_r;
  logic        occ_r;
  fcmp_t       c;
  logic        own;

  assign c    = fcmp(word_r, new_word);
  // insertion point is the first empty or smaller-word cell; every cell after it shifts
  assign own  = occ_r ? c.lt : 1'b1;
  assign take = prev_take || own;
  assign word = word_r;
  assign occ  = occ_r;

  // hold, shift from the left, or load the new word at the insertion point
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      occ_r <= 1'b0;
    end else if (ins && take && (prev_take ? prev_occ : 1'b1)) begin
      occ_r <= 1'b1;
    end
    if (ins && take) begin
      word_r <= prev_take ? prev_word : new_word;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/median_of_valid_samples.sv -----
`default_nettype none
// Median of the valid samples in a run.
// Input: pulse start with in_sample and in_last_sample while busy is low;
// busy is always low, so one word is taken every cycle.
// Samples equal (IEEE) to the missing or bad marker are dropped; the rest
// enter a row of MAX_VALUES compare cells kept in descending order, one
// insertion per cycle through the row's broadcast compare.
// On a last sample the result appears in the next cycle on out_median_value,
// out_found and out_overflowed with out_strobe high for one cycle; the
// receiver cannot stall, and a new run may start in the next cycle.
// Throughput: 1 word per cycle, set by the single compare-and-shift step
// of each cell. Markers are written through the cfg_ APB port at 0x0 and
// 0x4, by the user only while idle (the block does not enforce this).
// Reset (rst_n low, synchronous) empties the row and clears both markers.
module median_of_valid_samples
  import movs_pkg::*;
#(
  parameter int MAX_VALUES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_sample,
  input  wire logic        in_last_sample,
  output logic             out_strobe,
  output logic [31:0]      out_median_value,
  output logic             out_found,
  output logic             out_overflowed,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int CW = $clog2(MAX_VALUES + 1);

  logic [31:0]   missing_r, bad_r;
  logic [CW-1:0] count_r;
  logic          ovf_r;
  logic [MAX_VALUES-1:0] take, occ;
  logic [31:0]   words [MAX_VALUES];
  logic          acc, keep, full, ins;
  fcmp_t         cm, cb;
  logic [CW-1:0] n_new;
  logic [CW-1:0] med_idx;
  logic          ovf_new;
  logic [31:0]   out_nxt_val;

  assign busy       = 1'b0;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_BAD) ? bad_r : missing_r;

  // write the markers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      missing_r <= '0;
      bad_r     <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2] == REG_BAD) bad_r <= cfg_pwdata;
      else missing_r <= cfg_pwdata;
    end
  end

  assign acc  = start && !busy;
  assign cm   = fcmp(in_sample, missing_r);
  assign cb   = fcmp(in_sample, bad_r);
  assign keep = acc && !cm.eq && !cb.eq;
  assign full = (count_r == CW'(MAX_VALUES));
  assign ins  = keep && !full;

  // row of cells; cell 0 sees an untaken left neighbour
  genvar g;
  for (g = 0; g < MAX_VALUES; g++) begin : g_cell
    movs_cell u_cell (
      .clk(clk), .rst_n(rst_n), .ins(ins), .clr(acc && in_last_sample),
      .new_word(in_sample),
      .prev_take((g == 0) ? 1'b0 : take[(g == 0) ? 0 : g-1]),
      .prev_word(words[(g == 0) ? 0 : g-1]),
      .prev_occ(occ[(g == 0) ? 0 : g-1]),
      .take(take[g]), .word(words[g]), .occ(occ[g])
    );
  end

  // count and overflow including this word; median read from the row
  assign n_new   = count_r + CW'(ins);
  assign ovf_new = ovf_r || (keep && full);
  assign med_idx = n_new >> 1;

  always_comb begin
    // median position after inserting the current word
    logic [31:0] m;
    m = in_sample;
    for (int i = 0; i < MAX_VALUES; i++) begin
      if (CW'(i) == med_idx) begin
        if (!ins || !take[i]) m = words[i];
        else if (i > 0 && take[(i > 0) ? i-1 : 0]) m = words[(i > 0) ? i-1 : 0];
        else m = in_sample;
      end
    end
    out_nxt_val = m;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      ovf_r      <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= acc && in_last_sample;
      if (acc && in_last_sample) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else begin
        count_r <= n_new;
        ovf_r   <= ovf_new;
      end
    end
    if (acc && in_last_sample) begin
      out_found        <= (n_new != '0);
      out_median_value <= (n_new != '0) ? out_nxt_val : missing_r;
      out_overflowed   <= (n_new != '0) && ovf_new;
    end
  end

  // count never exceeds the row
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(MAX_VALUES))
    else $error("count overflow");
  // strobe follows an accepted last word
  a_str: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_last_sample) |=> out_strobe) else $error("missing strobe");
  // a full row takes no insertion
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !(acc && in_last_sample)) |=> count_r == CW'(MAX_VALUES)) else $error("full");
endmodule
`default_nettype wire

// ----- tb/median_of_valid_samples_tb.sv -----
`default_nettype none
module median_of_valid_samples_tb;
  import movs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [31:0] median_value;
    logic        found;
    logic        overflowed;
  } median_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_sample = '0;
  logic        in_last_sample = 1'b0;
  logic        out_strobe;
  logic [31:0] out_median_value;
  logic        out_found;
  logic        out_overflowed;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  median_of_valid_samples u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sample(in_sample), .in_last_sample(in_last_sample),
    .out_strobe(out_strobe), .out_median_value(out_median_value),
    .out_found(out_found), .out_overflowed(out_overflowed),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [31:0]  missing_mark;
  logic [31:0]  bad_mark;
  logic [31:0]  run_sorted [DEPTH];
  int           run_kept;
  logic         run_spilled;
  median_word_t median_queue [$];
  int           send_idle_pct;
  int           errors;
  longint       cycle_count;

  // IEEE ordering, written independently: returns a<b, a==b (NaN unordered)
  function automatic logic f_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 0);
  endfunction

  function automatic logic f_equal(input logic [31:0] a, input logic [31:0] b);
    if (f_nan(a) || f_nan(b)) return 1'b0;
    if (a[30:0] == 0 && b[30:0] == 0) return 1'b1;
    return a == b;
  endfunction

  function automatic logic f_less(input logic [31:0] a, input logic [31:0] b);
    if (f_nan(a) || f_nan(b) || f_equal(a, b)) return 1'b0;
    if (a[31] && !b[31]) return 1'b1;
    if (!a[31] && b[31]) return 1'b0;
    if (!a[31]) return a[30:0] < b[30:0];
    return a[30:0] > b[30:0];
  endfunction

  // insert one word into the run and queue a median on the last word
  task automatic predict_median(input logic [31:0] s, input logic last);
    int pos;
    median_word_t r;
    if (!f_equal(s, missing_mark) && !f_equal(s, bad_mark)) begin
      if (run_kept >= DEPTH) begin
        run_spilled = 1'b1;
      end else begin
        pos = 0;
        while (pos < run_kept && !f_less(run_sorted[pos], s)) pos++;
        for (int i = run_kept; i > pos; i--) run_sorted[i] = run_sorted[i-1];
        run_sorted[pos] = s;
        run_kept++;
      end
    end
    if (last) begin
      r.median_value = (run_kept == 0) ? missing_mark : run_sorted[run_kept/2];
      r.found = (run_kept != 0);
      r.overflowed = run_spilled;
      median_queue.push_back(r);
      run_kept = 0;
      run_spilled = 1'b0;
    end
  endtask

  // send one word, with random idle cycles ahead of it; start is left high
  task automatic send_word(input logic [31:0] s, input logic last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_sample <= s;
    in_last_sample <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_median(s, last);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
    start <= 1'b0;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_MISSING) missing_mark = value;
    else bad_mark = value;
  endtask

  task automatic drain_medians();
    start <= 1'b0;
    while (median_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // values that often collide with markers or each other
  function automatic logic [31:0] pick_sample(input logic [31:0] a, input logic [31:0] b);
    case ($urandom_range(9))
      0: return a;
      1: return b;
      2: return 32'h0000_0000;
      3: return 32'h8000_0000;
      4: return {1'($urandom_range(1)), 8'd127 + 8'($urandom_range(3)), 23'd0};
      5: return {1'($urandom_range(1)), 8'hFF, 23'd0};
      default: begin
        logic [31:0] v;
        v = $urandom;
        if (f_nan(v)) v[30] = 1'b0;
        return v;
      end
    endcase
  endfunction

  task automatic send_run(input int len);
    for (int i = 0; i < len; i++)
      send_word(pick_sample(missing_mark, bad_mark), i == len - 1);
  endtask

  // edge values, empty runs, signed zeros, equal values, overflow
  task automatic test_directed();
    send_word(32'h3F80_0000, 1'b1);
    send_word(32'h0000_0000, 1'b1);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h4000_0000, 1'b1);
    send_word(32'hFF80_0000, 1'b0);
    send_word(32'h7F80_0000, 1'b0);
    send_word(32'hFFFF_FFFF & 32'hFF7F_FFFF, 1'b0);
    send_word(32'h7F7F_FFFF, 1'b1);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h3F80_0000, 1'b1);
    write_reg(REG_BAD, 32'h4000_0000);
    write_reg(REG_MISSING, 32'hBF80_0000);
    send_word(32'h4000_0000, 1'b0);
    send_word(32'hBF80_0000, 1'b1);
    send_word(32'hBF80_0000, 1'b0);
    send_word(32'h4000_0000, 1'b0);
    send_word(32'h3F00_0000, 1'b1);
    drain_medians();
    for (int i = 0; i < DEPTH + 3; i++)
      send_word($urandom & 32'h3FFF_FFFF, i == DEPTH + 2);
    drain_medians();
  endtask

  task automatic test_random(input int words, input int idle_pct);
    int sent;
    send_idle_pct = idle_pct;
    sent = 0;
    while (sent < words) begin
      int len;
      len = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
      send_run(len);
      sent += len;
    end
    drain_medians();
  endtask

  task automatic test_markers();
    write_reg(REG_MISSING, 32'hFFFF_FFFF);
    write_reg(REG_BAD, 32'h0000_0000);
    test_random(150, 0);
    write_reg(REG_MISSING, 32'h8000_0000);
    write_reg(REG_BAD, 32'h7FFF_FFFF);
    test_random(150, 47);
    write_reg(REG_MISSING, $urandom);
    write_reg(REG_BAD, 32'h3F80_0000);
    test_random(150, 17);
  endtask

  // compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    median_word_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_strobe) begin
      if (median_queue.size() == 0) begin
        $error("median result with nothing expected: %h", out_median_value);
        errors++;
      end else begin
        want = median_queue.pop_front();
        if (out_median_value !== want.median_value) begin
          $error("median_value expected %h actual %h", want.median_value, out_median_value);
          errors++;
        end
        if (out_found !== want.found) begin
          $error("found expected %b actual %b", want.found, out_found);
          errors++;
        end
        if (out_overflowed !== want.overflowed) begin
          $error("overflowed expected %b actual %b", want.overflowed, out_overflowed);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycle_count = 0;
    missing_mark = '0;
    bad_mark = '0;
    run_kept = 0;
    run_spilled = 1'b0;
    send_idle_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(300, 0);
    test_random(200, 47);
    test_random(200, 17);
    test_markers();
    write_reg(REG_MISSING, 32'h0000_0000);
    write_reg(REG_BAD, 32'h0000_0000);
    test_random(100, 0);
    drain_medians();
    if (errors == 0 && median_queue.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- median_of_valid_samples.f -----
hdl/movs_pkg.sv
hdl/movs_cell.sv
hdl/median_of_valid_samples.sv
tb/median_of_valid_samples_tb.sv
